@@ rtl/rtt_ewma_pkg.sv @@
// Shared types and constants for the round-trip time estimator.
// No dependencies; used by the top level and its port checker.
package rtt_ewma_pkg;

   typedef logic [1:0]  status_type;
   typedef logic [31:0] time_type;
   typedef logic [38:0] q8_type;
   typedef logic [10:0] weight_type;
   typedef logic [7:0]  fill_type;

   localparam status_type ST_PUSHED    = 2'd0;
   localparam status_type ST_MEASURED  = 2'd1;
   localparam status_type ST_OVERFLOW  = 2'd2;
   localparam status_type ST_UNDERFLOW = 2'd3;

   localparam logic MODE_SEND = 1'b0;
   localparam logic MODE_ACK  = 1'b1;

   localparam weight_type WEIGHT_ONE   = 11'd1024;
   localparam weight_type WEIGHT_RESET = 11'd307;

   // Blend accumulator: 39-bit average times 11-bit weight, two terms plus rounding.
   localparam int BLEND_W = 50;
   localparam int ROUND_HALF = 512;
   localparam int BLEND_SHIFT = 10;

endpackage

@@ rtl/rtt_timestamp_fifo_ewma.sv @@
// Round-trip time estimator: timestamp ring FIFO plus moving average of one-way delay.
// Depends on rtt_ewma_pkg.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_mode, req_time_us
//   rsp     | out       | rsp_valid / rsp_stall | rsp_status, rsp_rtt_us, rsp_delay_q8,
//           |           |                       | rsp_avg_delay_q8, rsp_fill_level
//   csr     | in        | csr_valid / csr_ready | csr_new_weight
//
// One event is taken per cycle while req_stall is low. Each result is registered
// in the first stage, with the registered timestamp memory read, and then in the
// second stage, with the average update.
// Reset is synchronous, clears pointers, fill count and average, and sets the first-sample flag;
// the timestamp memory is not cleared, an entry is only read after it is written.
// A stalled result holds both stages; req_stall rises only when both stages are full.
module rtt_timestamp_fifo_ewma #(
   parameter int FIFO_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [31:0] req_time_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_rtt_us,
   output logic [38:0] rsp_delay_q8,
   output logic [38:0] rsp_avg_delay_q8,
   output logic [7:0]  rsp_fill_level,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_new_weight
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);
   localparam int BW = rtt_ewma_pkg::BLEND_W;

   // Configuration
   rtt_ewma_pkg::weight_type weight_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= rtt_ewma_pkg::WEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         weight_ff <= (csr_new_weight > rtt_ewma_pkg::WEIGHT_ONE) ?
                      rtt_ewma_pkg::WEIGHT_ONE : csr_new_weight;
      end
   end

   // Pipeline control
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic s1_move;
   logic req_accept;

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Stage 1: FIFO bookkeeping and timestamp read
   rtt_ewma_pkg::time_type store_mem [FIFO_DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;
   rtt_ewma_pkg::status_type status_in;

   rtt_ewma_pkg::status_type s1_status_ff;
   rtt_ewma_pkg::time_type   s1_now_ff;
   rtt_ewma_pkg::time_type   s1_then_ff;
   rtt_ewma_pkg::fill_type   s1_fill_ff;

   assign push_ok = req_accept && (req_mode == rtt_ewma_pkg::MODE_SEND) && (count_ff != FULL_CNT);
   assign pop_ok  = req_accept && (req_mode == rtt_ewma_pkg::MODE_ACK) && (count_ff != '0);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_comb begin
      priority if (req_mode == rtt_ewma_pkg::MODE_SEND) begin
         status_in = (count_ff == FULL_CNT) ? rtt_ewma_pkg::ST_OVERFLOW
                                            : rtt_ewma_pkg::ST_PUSHED;
      end else begin
         status_in = (count_ff == '0) ? rtt_ewma_pkg::ST_UNDERFLOW
                                      : rtt_ewma_pkg::ST_MEASURED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         store_mem[wr_ptr_ff] <= req_time_us;
      end
      if (pop_ok) begin
         s1_then_ff <= store_mem[rd_ptr_ff];
      end
      if (req_accept) begin
         s1_status_ff <= status_in;
         s1_now_ff    <= req_time_us;
         s1_fill_ff   <= 8'(count_in);
      end
   end

   // Stage 2: delay and moving average
   rtt_ewma_pkg::q8_type avg_ff, avg_in;
   logic                 first_ff;
   logic                 measured;
   rtt_ewma_pkg::time_type rtt;
   rtt_ewma_pkg::q8_type   delay;
   rtt_ewma_pkg::weight_type keep_weight;
   logic [BW-1:0]          blend_sum;

   assign measured    = (s1_status_ff == rtt_ewma_pkg::ST_MEASURED);
   assign rtt         = s1_now_ff - s1_then_ff;
   assign delay       = {rtt, 7'd0};
   assign keep_weight = rtt_ewma_pkg::WEIGHT_ONE - weight_ff;
   assign blend_sum   = BW'(avg_ff) * BW'(keep_weight) + BW'(delay) * BW'(weight_ff)
                      + BW'(rtt_ewma_pkg::ROUND_HALF);

   always_comb begin
      avg_in = avg_ff;
      if (s1_move && measured) begin
         avg_in = first_ff ? delay
                           : blend_sum[rtt_ewma_pkg::BLEND_SHIFT +: 39];
      end
   end

   rtt_ewma_pkg::status_type rsp_status_ff;
   rtt_ewma_pkg::time_type   rsp_rtt_ff;
   rtt_ewma_pkg::q8_type     rsp_delay_ff;
   rtt_ewma_pkg::q8_type     rsp_avg_ff;
   rtt_ewma_pkg::fill_type   rsp_fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff       <= '0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         avg_ff <= avg_in;
         if (s1_move && measured) begin
            first_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_status_ff <= s1_status_ff;
         rsp_rtt_ff    <= measured ? rtt : '0;
         rsp_delay_ff  <= measured ? delay : '0;
         rsp_avg_ff    <= avg_in;
         rsp_fill_ff   <= s1_fill_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_rtt_us       = rsp_rtt_ff;
   assign rsp_delay_q8     = rsp_delay_ff;
   assign rsp_avg_delay_q8 = rsp_avg_ff;
   assign rsp_fill_level   = rsp_fill_ff;

endmodule

@@ rtl/rtt_ewma_checker.sv @@
// Port-level checks for the round-trip time estimator, bound to its top level.
// Depends on rtt_ewma_pkg and rtt_timestamp_fifo_ewma.
module rtt_ewma_checker #(
   parameter int FIFO_DEPTH = 128
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_rtt_us,
   input logic [38:0] rsp_delay_q8,
   input logic [38:0] rsp_avg_delay_q8,
   input logic [7:0]  rsp_fill_level
);

   localparam logic [7:0] FULL_FILL = 8'(FIFO_DEPTH);

   // Held transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_rtt_us)
         && $stable(rsp_delay_q8) && $stable(rsp_avg_delay_q8) && $stable(rsp_fill_level))
      else $error("rsp transaction changed while stalled");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rtt_ewma_pkg::ST_UNDERFLOW) |-> rsp_fill_level == 8'd0)
      else $error("underflow reported with entries waiting");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rtt_ewma_pkg::ST_OVERFLOW) |-> rsp_fill_level == FULL_FILL)
      else $error("overflow reported with room left");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != rtt_ewma_pkg::ST_MEASURED)
         |-> (rsp_rtt_us == 32'd0) && (rsp_delay_q8 == 39'd0))
      else $error("rtt or delay nonzero without a measurement");

   a_delay_half: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rtt_ewma_pkg::ST_MEASURED)
         |-> rsp_delay_q8 == {rsp_rtt_us, 7'd0})
      else $error("delay is not half the round-trip time");

endmodule

bind rtt_timestamp_fifo_ewma rtt_ewma_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_rtt_ewma_checker (.*);

@@ tb/sv/tb.sv @@
// Self-checking bench for rtt_timestamp_fifo_ewma: send/ack transactions with in-order
// checking of every result against an in-bench estimator of FIFO, RTT and moving average.
// Depends on rtt_ewma_pkg and the rtt_timestamp_fifo_ewma RTL.
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 128;
   localparam int SETTLE_CYCLES = 4;
   localparam int SHOWN_MISMATCHES = 10;

   typedef struct {
      logic                   mode;
      rtt_ewma_pkg::time_type stamp;
   } net_event_type;

   typedef struct {
      rtt_ewma_pkg::status_type status;
      rtt_ewma_pkg::time_type   rtt;
      rtt_ewma_pkg::q8_type     delay;
      rtt_ewma_pkg::q8_type     avg;
      rtt_ewma_pkg::fill_type   fill;
   } rtt_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_mode;
   logic [31:0] req_time_us;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_rtt_us;
   logic [38:0] rsp_delay_q8;
   logic [38:0] rsp_avg_delay_q8;
   logic [7:0]  rsp_fill_level;
   logic        csr_valid;
   logic        csr_ready;
   logic [10:0] csr_new_weight;

   // Estimator state
   rtt_ewma_pkg::time_type   ts_store [DEPTH];
   int                       rd_ptr;
   int                       wr_ptr;
   int                       ts_count;
   rtt_ewma_pkg::q8_type     avg_q8;
   logic                     first_pending;
   rtt_ewma_pkg::weight_type cur_weight;

   net_event_type          pending_events[$];
   rtt_result_type         predicted_results[$];
   net_event_type          next_evt;
   rtt_result_type         seen;
   logic                   req_taken;
   logic                   calm;
   rtt_ewma_pkg::time_type wall_us;
   int                     errors;

   rtt_timestamp_fifo_ewma #(
      .FIFO_DEPTH(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_time_us(req_time_us),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_rtt_us(rsp_rtt_us),
      .rsp_delay_q8(rsp_delay_q8),
      .rsp_avg_delay_q8(rsp_avg_delay_q8),
      .rsp_fill_level(rsp_fill_level),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_new_weight(csr_new_weight)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rtt_result_type estimate_rtt(logic mode,
                                                   rtt_ewma_pkg::time_type now_us);
      rtt_result_type         r;
      rtt_ewma_pkg::time_type sent_us;
      logic [63:0]            blend_sum;
      r = '{rtt_ewma_pkg::ST_PUSHED, '0, '0, '0, '0};
      if (mode == rtt_ewma_pkg::MODE_SEND) begin
         if (ts_count >= DEPTH) begin
            r.status = rtt_ewma_pkg::ST_OVERFLOW;
         end else begin
            ts_store[wr_ptr] = now_us;
            wr_ptr = (wr_ptr == DEPTH - 1) ? 0 : wr_ptr + 1;
            ts_count++;
         end
      end else if (ts_count == 0) begin
         r.status = rtt_ewma_pkg::ST_UNDERFLOW;
      end else begin
         sent_us = ts_store[rd_ptr];
         rd_ptr = (rd_ptr == DEPTH - 1) ? 0 : rd_ptr + 1;
         ts_count--;
         r.rtt = now_us - sent_us;
         r.delay = {r.rtt, 7'b0};
         if (first_pending) begin
            avg_q8 = r.delay;
            first_pending = 1'b0;
         end else begin
            blend_sum = 64'(avg_q8) * (64'd1024 - 64'(cur_weight))
                      + 64'(r.delay) * 64'(cur_weight) + 64'd512;
            avg_q8 = rtt_ewma_pkg::q8_type'(blend_sum >> 10);
         end
         r.status = rtt_ewma_pkg::ST_MEASURED;
      end
      r.avg = avg_q8;
      r.fill = rtt_ewma_pkg::fill_type'(ts_count);
      return r;
   endfunction

   task automatic report_mismatch(string what, rtt_result_type want, rtt_result_type got);
      errors++;
      if (errors <= SHOWN_MISMATCHES) begin
         $display("%0t %s", $realtime, what);
         $display("   expected status %0d rtt %0h delay %0h avg %0h fill %0d",
                  want.status, want.rtt, want.delay, want.avg, want.fill);
         $display("   actual   status %0d rtt %0h delay %0h avg %0h fill %0d",
                  got.status, got.rtt, got.delay, got.avg, got.fill);
      end
   endtask

   // Predict on request transactions, check on response transactions.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted_results.push_back(estimate_rtt(req_mode, req_time_us));
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_status, rsp_rtt_us, rsp_delay_q8, rsp_avg_delay_q8, rsp_fill_level};
            if (predicted_results.size() == 0) begin
               report_mismatch("result with no request outstanding", seen, seen);
            end else if (seen.status !== predicted_results[0].status
                         || seen.rtt !== predicted_results[0].rtt
                         || seen.delay !== predicted_results[0].delay
                         || seen.avg !== predicted_results[0].avg
                         || seen.fill !== predicted_results[0].fill) begin
               report_mismatch("result mismatch", predicted_results.pop_front(), seen);
            end else begin
               void'(predicted_results.pop_front());
            end
         end
      end
   end

   // Request driver: advance only after the current transaction was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (pending_events.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
            next_evt = pending_events.pop_front();
            req_valid <= 1'b1;
            req_mode <= next_evt.mode;
            req_time_us <= next_evt.stamp;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 17);
   end

   task automatic add_event(logic mode, rtt_ewma_pkg::time_type stamp);
      pending_events.push_back('{mode, stamp});
   endtask

   task automatic queue_traffic(int count, int ack_pct);
      rtt_ewma_pkg::time_type stamp;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0) begin
            wall_us += $urandom();
         end else begin
            wall_us += $urandom_range(3000);
         end
         stamp = ($urandom_range(7) == 0) ? rtt_ewma_pkg::time_type'($urandom()) : wall_us;
         add_event(($urandom_range(99) < ack_pct) ? rtt_ewma_pkg::MODE_ACK
                                                  : rtt_ewma_pkg::MODE_SEND, stamp);
      end
   endtask

   // Hold until the sender is empty and every result is back, then let the pipe settle.
   task automatic drain_results();
      while (pending_events.size() != 0 || req_valid || predicted_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_weight(rtt_ewma_pkg::weight_type value);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_new_weight <= value;
      do @(posedge clock); while (!csr_ready);
      cur_weight = (value > rtt_ewma_pkg::WEIGHT_ONE) ? rtt_ewma_pkg::WEIGHT_ONE : value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = rtt_ewma_pkg::MODE_SEND;
      req_time_us = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_new_weight = '0;
      req_taken = 1'b0;
      calm = 1'b0;
      errors = 0;
      rd_ptr = 0;
      wr_ptr = 0;
      ts_count = 0;
      avg_q8 = '0;
      first_pending = 1'b1;
      cur_weight = rtt_ewma_pkg::WEIGHT_RESET;
      wall_us = $urandom();

      // Directed: empty pop, largest RTT on first sample, clock wrap, zero RTT, FIFO order.
      add_event(rtt_ewma_pkg::MODE_ACK, 32'd100);
      add_event(rtt_ewma_pkg::MODE_SEND, 32'h0000_0000);
      add_event(rtt_ewma_pkg::MODE_ACK, 32'hFFFF_FFFF);
      add_event(rtt_ewma_pkg::MODE_SEND, 32'hFFFF_FFF0);
      add_event(rtt_ewma_pkg::MODE_ACK, 32'h0000_0010);
      add_event(rtt_ewma_pkg::MODE_SEND, 32'd12345);
      add_event(rtt_ewma_pkg::MODE_ACK, 32'd12345);
      add_event(rtt_ewma_pkg::MODE_SEND, 32'd1000);
      add_event(rtt_ewma_pkg::MODE_SEND, 32'd2000);
      add_event(rtt_ewma_pkg::MODE_SEND, 32'd3000);
      add_event(rtt_ewma_pkg::MODE_ACK, 32'd1500);
      add_event(rtt_ewma_pkg::MODE_ACK, 32'd2600);
      add_event(rtt_ewma_pkg::MODE_ACK, 32'd3900);
      add_event(rtt_ewma_pkg::MODE_ACK, 32'd50);
      add_event(rtt_ewma_pkg::MODE_SEND, 32'h8000_0000);
      add_event(rtt_ewma_pkg::MODE_ACK, 32'h7FFF_FFFF);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_weight(11'd0);
      queue_traffic(60, 50);
      queue_traffic(60, 35);

      // Full weight, no idling: fill past the top, then drain past empty.
      write_weight(rtt_ewma_pkg::WEIGHT_ONE);
      calm = 1'b1;
      queue_traffic(130, 0);
      queue_traffic(135, 100);
      drain_results();
      calm = 1'b0;

      write_weight(11'h7FF);
      queue_traffic(80, 60);
      queue_traffic(80, 40);

      write_weight(11'd1);
      queue_traffic(100, 50);

      write_weight(rtt_ewma_pkg::weight_type'($urandom_range(2047)));
      queue_traffic(100, $urandom_range(30, 70));

      write_weight(rtt_ewma_pkg::weight_type'($urandom_range(1024)));
      queue_traffic(100, 50);

      drain_results();
      if (predicted_results.size() != 0) begin
         errors++;
      end
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #400_000;
      $display("tb: errors");
      $finish;
   end

endmodule
